// ===== hw/rtl/bcdec_pkg.sv =====
// bcdec_pkg: shared types, format codes and divide-by-constant helpers
`default_nettype none
package bcdec_pkg;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t a;
        byte_t b;
        byte_t g;
        byte_t r;
    } rgba_t;

    typedef rgba_t [3:0] cpal_t;
    typedef byte_t [7:0] apal_t;
    typedef byte_t [2:0] rgb_t;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_BC1 = 2'd0;
    localparam mode_t MODE_BC2 = 2'd1;
    localparam mode_t MODE_BC3 = 2'd2;

    // rgb565 to rgb888 by replicating the top bits
    function automatic rgb_t widen565(input logic [15:0] c);
        rgb_t res;
        res[0] = {c[15:11], c[15:13]};
        res[1] = {c[10:5], c[10:9]};
        res[2] = {c[4:0], c[4:2]};
        return res;
    endfunction

    // exact floor(x / 3) for x < 768
    function automatic byte_t div3(input logic [9:0] x);
        logic [20:0] prod;
        prod = 21'(x) * 21'd683;
        return prod[18:11];
    endfunction

    // exact floor(x / 7) for x < 1792
    function automatic byte_t div7(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'd2341;
        return prod[21:14];
    endfunction

    // exact floor(x / 5) for x < 1280
    function automatic byte_t div5(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'd3277;
        return prod[21:14];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bcdec_palette.sv =====
// bcdec_palette: colour and alpha palettes of one compressed block
`default_nettype none
module bcdec_palette (
    input  wire logic [63:0]       color_block,
    input  wire logic [63:0]       alpha_block,
    input  wire bcdec_pkg::mode_t  codec_mode,
    output bcdec_pkg::cpal_t       cpal,
    output bcdec_pkg::apal_t       apal
);

    bcdec_pkg::rgb_t  e0;
    bcdec_pkg::rgb_t  e1;
    bcdec_pkg::byte_t a0;
    bcdec_pkg::byte_t a1;
    logic             four_color;
    logic [9:0]       sum2;
    logic [9:0]       sum3;
    logic [8:0]       sum_mid;

    assign e0 = bcdec_pkg::widen565(color_block[15:0]);
    assign e1 = bcdec_pkg::widen565(color_block[31:16]);
    assign four_color = (color_block[15:0] > color_block[31:16])
                     || (codec_mode != bcdec_pkg::MODE_BC1);
    assign a0 = alpha_block[7:0];
    assign a1 = alpha_block[15:8];

    always_comb
    begin
        sum2    = '0;
        sum3    = '0;
        sum_mid = '0;
        cpal[0] = {8'hff, e0[2], e0[1], e0[0]};
        cpal[1] = {8'hff, e1[2], e1[1], e1[0]};
        cpal[2].a = 8'hff;
        cpal[3].a = four_color ? 8'hff : 8'h00;
        for (int k = 0; k < 3; k++)
        begin
            sum2    = {1'b0, e0[k], 1'b0} + {2'b00, e1[k]};
            sum3    = {2'b00, e0[k]} + {1'b0, e1[k], 1'b0};
            sum_mid = {1'b0, e0[k]} + {1'b0, e1[k]};
            case (k)
                0:
                begin
                    cpal[2].r = four_color ? bcdec_pkg::div3(sum2) : sum_mid[8:1];
                    cpal[3].r = four_color ? bcdec_pkg::div3(sum3) : 8'h00;
                end
                1:
                begin
                    cpal[2].g = four_color ? bcdec_pkg::div3(sum2) : sum_mid[8:1];
                    cpal[3].g = four_color ? bcdec_pkg::div3(sum3) : 8'h00;
                end
                default:
                begin
                    cpal[2].b = four_color ? bcdec_pkg::div3(sum2) : sum_mid[8:1];
                    cpal[3].b = four_color ? bcdec_pkg::div3(sum3) : 8'h00;
                end
            endcase
        end
    end

    always_comb
    begin
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                apal[k + 1] = bcdec_pkg::div7(11'((7 - k) * a0 + k * a1));
            end
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
            begin
                apal[k + 1] = bcdec_pkg::div5(11'((5 - k) * a0 + k * a1));
            end
            apal[6] = 8'h00;
            apal[7] = 8'hff;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bc1_bc2_bc3_block_decoder.sv =====
// bc1_bc2_bc3_block_decoder: bc1/bc2/bc3 4x4 block to sixteen rgba8 texels
//
//  channel  dir  bits  contents
//  s_*      in   128   tdata: color_block [63:0], alpha_block [127:64]
//  m_*      out  40    tdata: texel_index, red, green, blue, alpha; tlast: last_texel
//  cfg_*    in   2     codec_mode, written when cfg_wr_en is high
//
//  one item in, sixteen texel items out, one per cycle unless m_tready stalls the output
//  an input register and a palette stage let the next block wait while the
//  current one is emitted; blocks pass input, palette and output registers
//  rst_n clears valids and codec_mode asynchronously
//  m_tready low with an item valid holds the output register and stalls the palette stage
`default_nettype none
module bc1_bc2_bc3_block_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,     // color_block, alpha_block
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,     // texel_index, red, green, blue, alpha, zero pad
    output logic              m_tlast,     // last_texel
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_wr_data  // codec_mode
);

    bcdec_pkg::mode_t  mode_reg;

    logic              in_vld_reg;
    logic [127:0]      in_blk_reg;

    logic              pal_vld_reg;
    logic              pal_vld_next;
    logic [3:0]        cnt_reg;
    logic [3:0]        cnt_next;
    bcdec_pkg::cpal_t  cpal_reg;
    bcdec_pkg::apal_t  apal_reg;
    logic [31:0]       cidx_reg;
    logic [63:0]       ablk_reg;

    logic              out_vld_reg;
    logic              out_vld_next;
    logic [35:0]       out_data_reg;
    logic              out_last_reg;

    bcdec_pkg::cpal_t  cpal_w;
    bcdec_pkg::apal_t  apal_w;

    logic              in_acc;
    logic              in_take;
    logic              emit;
    logic              pal_done;

    logic [1:0]        ci;
    logic [3:0]        nib;
    logic [2:0]        ai;
    bcdec_pkg::rgba_t  texel;
    bcdec_pkg::byte_t  alpha_val;

    bcdec_palette u_pal (
        .color_block (in_blk_reg[63:0]),
        .alpha_block (in_blk_reg[127:64]),
        .codec_mode  (mode_reg),
        .cpal        (cpal_w),
        .apal        (apal_w)
    );

    assign emit     = pal_vld_reg && (!out_vld_reg || m_tready);
    assign pal_done = emit && (cnt_reg == 4'd15);
    assign in_take  = in_vld_reg && (!pal_vld_reg || pal_done);
    assign s_tready = !in_vld_reg || in_take;
    assign in_acc   = s_tvalid && s_tready;

    assign ci    = cidx_reg[2 * cnt_reg +: 2];
    assign nib   = ablk_reg[4 * cnt_reg +: 4];
    assign ai    = ablk_reg[16 + 3 * cnt_reg +: 3];
    assign texel = cpal_reg[ci];

    always_comb
    begin
        case (mode_reg)
            bcdec_pkg::MODE_BC1: alpha_val = texel.a;
            bcdec_pkg::MODE_BC2: alpha_val = {nib, nib};
            default:             alpha_val = apal_reg[ai];
        endcase
    end

    always_comb
    begin
        pal_vld_next = pal_vld_reg;
        cnt_next     = cnt_reg;
        if (in_take)
        begin
            pal_vld_next = 1'b1;
            cnt_next     = 4'd0;
        end
        else if (pal_done)
        begin
            pal_vld_next = 1'b0;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        out_vld_next = out_vld_reg;
        if (emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= bcdec_pkg::MODE_BC1;
            in_vld_reg  <= 1'b0;
            pal_vld_reg <= 1'b0;
            cnt_reg     <= 4'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (in_acc)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (in_take)
            begin
                in_vld_reg <= 1'b0;
            end
            pal_vld_reg <= pal_vld_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_blk_reg <= s_tdata;
        end
        if (in_take)
        begin
            cpal_reg <= cpal_w;
            apal_reg <= apal_w;
            cidx_reg <= in_blk_reg[63:32];
            ablk_reg <= in_blk_reg[127:64];
        end
        if (emit)
        begin
            out_data_reg <= {alpha_val, texel.b, texel.g, texel.r, cnt_reg};
            out_last_reg <= (cnt_reg == 4'd15);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bcdec_checker.sv =====
// bcdec_checker: port-level checks on the block decoder, bound to the top level
`default_nettype none
module bcdec_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [39:0]  m_tdata,
    input wire logic         m_tlast
);

    // stalled result item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled item changed");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[3:0] == 4'd15)
        else $error("tlast on texel other than fifteen");

    a_idx_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == 4'd15 |-> m_tlast)
        else $error("texel fifteen without tlast");

    // texels of a block follow in order
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid
            |-> m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1)
        else $error("texel index out of sequence");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:36] == 4'd0)
        else $error("padding bits set");

endmodule

bind bc1_bc2_bc3_block_decoder bcdec_checker u_bcdec_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
);
`default_nettype wire
